@@ src/matrix_multiply_engine_top_defines.svh @@
// assertion macros for the matrix multiply engine
// no dependencies; included by matrix_multiply_engine_top.sv, which carries the assertions
`ifndef MATRIX_MULTIPLY_ENGINE_TOP_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MME_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MME_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MME_ASSERT(lbl, clk, rst_n, prop, msg)
`define MME_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ src/mme_pkg.sv @@
// shared types and constants of the matrix multiply engine
// no dependencies
`default_nettype none

package mme_pkg;

  localparam int DEF_MAX_DIM    = 8;
  localparam int DEF_ELEM_WIDTH = 16;

  localparam int DIM_W   = 4;   // width of a dimension register
  localparam int IDX_W   = 3;   // width of a row or column field
  localparam int VAL_W   = 16;  // width of the element field
  localparam int SUM_W   = 40;  // width of a product entry
  localparam int REQ_W   = 2;
  localparam int CFG_A_W = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_A  = 2'd0,
    REQ_LOAD_B  = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_t;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_t;

  // control that travels with one multiply-accumulate step
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic zero;
  } mac_ctl_t;

endpackage

`default_nettype wire

@@ src/matrix_multiply_engine_top.sv @@
// top level of the matrix multiply engine: element stores, sequencer, output register
// depends on mme_pkg, mme_mac and matrix_multiply_engine_top_defines.svh
`default_nettype none
`include "matrix_multiply_engine_top_defines.svh"

// Matrix multiply engine, C = A * B on signed Q8.8 elements. Load words (tuser
// REQ_LOAD_A or REQ_LOAD_B) write one element into the A or B store at row*MAX_DIM+col;
// a load whose row or column is at or above MAX_DIM is dropped.
// A compute word (tuser REQ_COMPUTE) streams every entry of C in row-major order as a
// Q24.16 sum, tlast on the final entry. Dimensions come from the config registers and
// saturate at MAX_DIM; a zero row or column count gives no output, a zero inner
// dimension gives all-zero entries. Each store is one single-port-write synchronous
// memory read at one address per cycle, so an entry reads its inner terms one after
// another and its sum then passes through the read, multiply and accumulate registers;
// a finished entry waits in the sequencer while the output register is still full.
// No word is accepted while a compute is running; the output register lets the
// next word in while the final entry still waits to be taken. Loads and reads never
// share a cycle, so the stores need no forwarding. Unwritten entries read as garbage.
module matrix_multiply_engine_top
  import mme_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input word channel
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [23:0]        in_tdata,   // elem_row[2:0], elem_col[5:3], elem_value[21:6]
  input  wire logic [REQ_W-1:0]   in_tuser,   // req_type[1:0]
  // result word channel
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [47:0]             out_tdata,  // out_row[2:0], out_col[5:3], dot_sum[45:6]
  output logic                    out_tlast,
  // config write port
  input  wire logic               cfg_we,
  input  wire logic [CFG_A_W-1:0] cfg_addr,
  input  wire logic [DIM_W-1:0]   cfg_wdata
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [DIM_W-1:0] MAXD = DIM_W'(MAX_DIM);

  // config registers
  logic [DIM_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic [DIM_W-1:0] nr, nk, nc, nk_eff;

  // sequencer
  state_t           state_r, state_nxt;
  logic [IW-1:0]    r_r, r_nxt, c_r, c_nxt, k_r, k_nxt;
  logic             k_last, r_last, c_last, entry_last;
  logic             sum_ok, out_free, out_load;
  logic             pend_r, pend_nxt;
  mac_ctl_t         beat, beat_s1_r;

  // input word fields
  logic [IDX_W-1:0]         in_row, in_col;
  logic signed [VAL_W-1:0]  in_val;
  logic                     in_acc, idx_ok, a_we, b_we;
  logic [AW-1:0]            wr_addr, a_addr, b_addr;
  logic [ELEM_WIDTH-1:0]    wr_data;

  // element stores
  logic [ELEM_WIDTH-1:0]    a_mem [DEPTH];
  logic [ELEM_WIDTH-1:0]    b_mem [DEPTH];
  logic [ELEM_WIDTH-1:0]    a_rd_r, b_rd_r;

  // mac
  logic [SUM_W-1:0]         mac_sum;
  logic                     mac_done;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic [SUM_W-1:0]         out_sum_r;
  logic                     out_last_r;

  assign in_row = in_tdata[2:0];
  assign in_col = in_tdata[5:3];
  assign in_val = $signed(in_tdata[21:6]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_RESET;
      inner_dim_r <= DIM_RESET;
      cols_b_r    <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_ROWS_A:    rows_a_r    <= cfg_wdata;
        CFG_INNER_DIM: inner_dim_r <= cfg_wdata;
        CFG_COLS_B:    cols_b_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // dimensions saturate at the store size
  assign nr     = (rows_a_r > MAXD) ? MAXD : rows_a_r;
  assign nk     = (inner_dim_r > MAXD) ? MAXD : inner_dim_r;
  assign nc     = (cols_b_r > MAXD) ? MAXD : cols_b_r;
  assign nk_eff = (nk == '0) ? DIM_W'(1) : nk;

  assign k_last     = (DIM_W'(k_r) == nk_eff - DIM_W'(1));
  assign r_last     = (DIM_W'(r_r) == nr - DIM_W'(1));
  assign c_last     = (DIM_W'(c_r) == nc - DIM_W'(1));
  assign entry_last = r_last && c_last;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign sum_ok    = mac_done || pend_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (req_t'(in_tuser) == REQ_COMPUTE) && (nr != '0) && (nc != '0)) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sum_ok && out_free) begin
          state_nxt = entry_last ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs and counters
  always_comb begin
    r_nxt    = r_r;
    c_nxt    = c_r;
    k_nxt    = k_r;
    beat     = '0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        r_nxt = '0;
        c_nxt = '0;
        k_nxt = '0;
      end
      ST_ISSUE: begin
        beat.valid = 1'b1;
        beat.first = (k_r == '0);
        beat.last  = k_last;
        beat.zero  = (nk == '0);
        k_nxt      = k_last ? '0 : k_r + IW'(1);
      end
      ST_WAIT: begin
        if (sum_ok && out_free) begin
          out_load = 1'b1;
          if (c_last) begin
            c_nxt = '0;
            r_nxt = r_r + IW'(1);
          end else begin
            c_nxt = c_r + IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // a finished sum that cannot leave yet is held in the mac accumulator
  assign pend_nxt = out_load ? 1'b0 : (mac_done ? 1'b1 : pend_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      r_r       <= '0;
      c_r       <= '0;
      k_r       <= '0;
      pend_r    <= 1'b0;
      beat_s1_r <= '0;
    end else begin
      state_r   <= state_nxt;
      r_r       <= r_nxt;
      c_r       <= c_nxt;
      k_r       <= k_nxt;
      pend_r    <= pend_nxt;
      beat_s1_r <= beat;
    end
  end

  // load path
  assign idx_ok  = (DIM_W'(in_row) < MAXD) && (DIM_W'(in_col) < MAXD);
  assign a_we    = in_acc && idx_ok && (req_t'(in_tuser) == REQ_LOAD_A);
  assign b_we    = in_acc && idx_ok && (req_t'(in_tuser) == REQ_LOAD_B);
  assign wr_addr = AW'(32'(in_row) * MAX_DIM + 32'(in_col));
  assign wr_data = ELEM_WIDTH'(in_val);

  // read path: A by row and inner index, B by inner index and column
  assign a_addr = AW'(32'(r_r) * MAX_DIM + 32'(k_r));
  assign b_addr = AW'(32'(k_r) * MAX_DIM + 32'(c_r));

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[wr_addr] <= wr_data;
    end
    a_rd_r <= a_mem[a_addr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[wr_addr] <= wr_data;
    end
    b_rd_r <= b_mem[b_addr];
  end

  mme_mac #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (beat_s1_r),
    .a_i    ($signed(a_rd_r)),
    .b_i    ($signed(b_rd_r)),
    .sum_o  (mac_sum),
    .done_o (mac_done)
  );

  // output register
  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r  <= IDX_W'(r_r);
      out_col_r  <= IDX_W'(c_r);
      out_sum_r  <= mac_sum;
      out_last_r <= entry_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_sum_r, out_col_r, out_row_r};
  assign out_tlast  = out_last_r;

  // a sum completes only while the sequencer waits for it
  `MME_ASSERT(a_done_in_wait, clk, rst_n, mac_done |-> (state_r == ST_WAIT), "sum done outside wait")
  // a second sum never lands on one not yet delivered
  `MME_ASSERT(a_no_double_sum, clk, rst_n, mac_done |-> !pend_r, "sum overwritten before delivery")
  // no entry starts while a finished sum is still held
  `MME_ASSERT(a_issue_clean, clk, rst_n, (state_r == ST_ISSUE) |-> !pend_r, "issue with pending sum")
  // inner index stays inside the active dimension
  `MME_ASSERT(a_k_range, clk, rst_n, (state_r == ST_ISSUE) |-> (DIM_W'(k_r) < nk_eff), "inner index out of range")
  // stores are never written during a compute
  `MME_ASSERT(a_no_load_busy, clk, rst_n, (a_we || b_we) |-> (state_r == ST_IDLE), "store write while busy")

endmodule

`default_nettype wire

@@ src/mme_mac.sv @@
// two-stage multiply-accumulate for one product entry
// depends on mme_pkg
`default_nettype none

module mme_mac
  import mme_pkg::*;
#(
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire mac_ctl_t                     ctl_i,
  input  wire logic signed [ELEM_WIDTH-1:0] a_i,
  input  wire logic signed [ELEM_WIDTH-1:0] b_i,
  output logic             [SUM_W-1:0]      sum_o,
  output logic                              done_o
);

  logic signed [2*ELEM_WIDTH-1:0] prod_r;
  mac_ctl_t                       ctl_p_r;
  logic        [SUM_W-1:0]        prod_ext;
  logic        [SUM_W-1:0]        acc_r;
  logic                           done_r;

  // sign extend or wrap the product to the sum width
  assign prod_ext = SUM_W'(prod_r);

  always_ff @(posedge clk) begin
    if (ctl_i.zero) begin
      prod_r <= '0;
    end else begin
      prod_r <= a_i * b_i;
    end
    if (ctl_p_r.valid) begin
      if (ctl_p_r.first) begin
        acc_r <= prod_ext;
      end else begin
        acc_r <= acc_r + prod_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_p_r <= '0;
      done_r  <= 1'b0;
    end else begin
      ctl_p_r <= ctl_i;
      done_r  <= ctl_p_r.valid & ctl_p_r.last;
    end
  end

  assign sum_o  = acc_r;
  assign done_o = done_r;

endmodule

`default_nettype wire
